[hw/rtl/mhc_pkg.sv]
// ----------------------------------------------------------------------------
// mhc_pkg
// Shared constants, types and tables of the compass heading core.
// ----------------------------------------------------------------------------
package mhc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;

	localparam int RAW_W   = 16;
	localparam int OFF_W   = 17;
	localparam int SCALE_W = 16;
	localparam int CAL_W   = 16;
	localparam int HEAD_W  = 15;
	localparam int SECT_W  = 3;

	// rotator datapath: cal value * 256 with CORDIC gain and sign headroom
	localparam int DW = 27;
	// angle accumulator in 1/65536 degree
	localparam int AW = 26;

	localparam int FULL_TURN      = 23040;
	localparam int HALF_TURN      = 11520;
	localparam int HALF_TURN_FINE = 11796480;
	localparam int SECT_FIRST     = 1440;
	localparam int SECT_SPAN      = 2880;
	localparam int SECT_LAST      = 21600;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 17;

	localparam logic [CFG_IW-1:0] REG_X_OFF   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_Y_OFF   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_Z_OFF   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_X_SCALE = 3'd3;
	localparam logic [CFG_IW-1:0] REG_Y_SCALE = 3'd4;
	localparam logic [CFG_IW-1:0] REG_Z_SCALE = 3'd5;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

	typedef struct packed {
		logic signed [CAL_W-1:0] x;
		logic signed [CAL_W-1:0] y;
		logic signed [CAL_W-1:0] z;
	} cal_vec_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [AW-1:0] atan_fine(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0:  r = 26'sd2949120;
			1:  r = 26'sd1740967;
			2:  r = 26'sd919879;
			3:  r = 26'sd466945;
			4:  r = 26'sd234379;
			5:  r = 26'sd117304;
			6:  r = 26'sd58666;
			7:  r = 26'sd29335;
			8:  r = 26'sd14668;
			9:  r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic int step_shift(input int i);
		return (i < ATAN_ENTRIES) ? i : ATAN_ENTRIES - 1;
	endfunction

endpackage

[hw/rtl/mhc_calib.sv]
// ----------------------------------------------------------------------------
// mhc_calib
// One axis: offset removal, soft-iron scaling, truncation and saturation.
// Three register stages, no stall.
// ----------------------------------------------------------------------------
module mhc_calib (
	input  logic                                 clk,
	input  logic signed [mhc_pkg::RAW_W-1:0]     raw,
	input  logic signed [mhc_pkg::OFF_W-1:0]     off_twice,
	input  logic        [mhc_pkg::SCALE_W-1:0]   scale,
	output logic signed [mhc_pkg::CAL_W-1:0]     cal
);
	import mhc_pkg::*;

	localparam int D_W = RAW_W + 2;
	localparam int P_W = D_W + SCALE_W + 1;
	localparam int Q_W = P_W - 13;

	logic signed [D_W-1:0]     d_s1;
	logic        [SCALE_W-1:0] scale_s1;
	logic signed [P_W-1:0]     p_s2;
	logic signed [CAL_W-1:0]   cal_s3;

	logic signed [P_W-1:0] p_bias;
	logic signed [Q_W-1:0] q;

	always_comb begin
		// round toward zero: bias negatives before the floor shift
		p_bias = p_s2 + (p_s2[P_W-1] ? P_W'(8191) : P_W'(0));
		q      = Q_W'(p_bias >>> 13);
	end

	always_ff @(posedge clk) begin
		d_s1     <= (D_W'(raw) <<< 1) - D_W'(off_twice);
		scale_s1 <= scale;
		p_s2     <= P_W'(d_s1) * $signed({1'b0, scale_s1});
		if (q > Q_W'(32767)) begin
			cal_s3 <= 16'sh7fff;
		end else if (q < -Q_W'(32768)) begin
			cal_s3 <= -16'sh8000;
		end else begin
			cal_s3 <= CAL_W'(q);
		end
	end

	assign cal = cal_s3;

endmodule

[hw/rtl/mhc_cordic.sv]
// ----------------------------------------------------------------------------
// mhc_cordic
// Pipelined vectoring CORDIC: half-plane fold, one stage per iteration,
// heading wrap and sector classification. Carries the calibrated vector.
// ----------------------------------------------------------------------------
module mhc_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  mhc_pkg::cal_vec_t                 in_cal,
	output logic                              out_valid,
	output mhc_pkg::cal_vec_t                 out_cal,
	output logic [mhc_pkg::HEAD_W-1:0]        out_heading,
	output logic [mhc_pkg::SECT_W-1:0]        out_sector
);
	import mhc_pkg::*;

	localparam int HH_W = AW - 9;

	logic signed [DW-1:0] ix_sk  [0:CORDIC_STEPS];
	logic signed [DW-1:0] iy_sk  [0:CORDIC_STEPS];
	logic signed [AW-1:0] ia_sk  [0:CORDIC_STEPS];
	cal_vec_t             cal_sk [0:CORDIC_STEPS];
	logic                 zy_sk  [0:CORDIC_STEPS];
	logic                 xn_sk  [0:CORDIC_STEPS];
	logic                 v_sk   [0:CORDIC_STEPS];

	logic                 v_sh, v_so;
	cal_vec_t             cal_sh, cal_so;
	logic [HEAD_W-1:0]    h_sh, h_so;
	logic [SECT_W-1:0]    sect_so;

	logic signed [DW-1:0] x256, y256;
	logic signed [HH_W-1:0] hh;
	logic [HEAD_W-1:0]    h_wrap;
	logic [SECT_W-1:0]    sect_cnt;

	// fold into the right half plane
	always_comb begin
		x256 = DW'(in_cal.x) <<< 8;
		y256 = DW'(in_cal.y) <<< 8;
	end

	always_ff @(posedge clk) begin
		cal_sk[0] <= in_cal;
		zy_sk[0]  <= (in_cal.y == '0);
		xn_sk[0]  <= in_cal.x[CAL_W-1];
		if (in_cal.x[CAL_W-1]) begin
			ix_sk[0] <= -x256;
			iy_sk[0] <= -y256;
			ia_sk[0] <= AW'(HALF_TURN_FINE);
		end else begin
			ix_sk[0] <= x256;
			iy_sk[0] <= y256;
			ia_sk[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else begin
			v_sk[0] <= in_valid;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam int SH = step_shift(k);
		localparam logic signed [AW-1:0] ATAN = atan_fine(k);

		logic signed [DW-1:0] xs, ys;

		assign xs = ix_sk[k] >>> SH;
		assign ys = iy_sk[k] >>> SH;

		always_ff @(posedge clk) begin
			cal_sk[k+1] <= cal_sk[k];
			zy_sk[k+1]  <= zy_sk[k];
			xn_sk[k+1]  <= xn_sk[k];
			if (!iy_sk[k][DW-1]) begin
				ix_sk[k+1] <= ix_sk[k] + ys;
				iy_sk[k+1] <= iy_sk[k] - xs;
				ia_sk[k+1] <= ia_sk[k] + ATAN;
			end else begin
				ix_sk[k+1] <= ix_sk[k] - ys;
				iy_sk[k+1] <= iy_sk[k] + xs;
				ia_sk[k+1] <= ia_sk[k] - ATAN;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k+1] <= 1'b0;
			end else begin
				v_sk[k+1] <= v_sk[k];
			end
		end
	end

	// fine angle to 1/64 degree, rounded, wrapped into one turn
	always_comb begin
		hh = HH_W'((ia_sk[CORDIC_STEPS] + AW'(512)) >>> 10);
		if (hh < 0) begin
			h_wrap = HEAD_W'(hh + HH_W'(FULL_TURN));
		end else if (hh >= HH_W'(FULL_TURN)) begin
			h_wrap = HEAD_W'(hh - HH_W'(FULL_TURN));
		end else begin
			h_wrap = HEAD_W'(hh);
		end
	end

	always_comb begin
		sect_cnt = '0;
		for (int k = 0; k < 7; k++) begin
			if (h_sh > HEAD_W'(SECT_FIRST + SECT_SPAN * k)) begin
				sect_cnt = sect_cnt + 1'b1;
			end
		end
		if (h_sh > HEAD_W'(SECT_LAST)) begin
			sect_cnt = '0;
		end
	end

	always_ff @(posedge clk) begin
		cal_sh <= cal_sk[CORDIC_STEPS];
		if (zy_sk[CORDIC_STEPS]) begin
			h_sh <= xn_sk[CORDIC_STEPS] ? HEAD_W'(HALF_TURN) : '0;
		end else begin
			h_sh <= h_wrap;
		end
		cal_so  <= cal_sh;
		h_so    <= h_sh;
		sect_so <= sect_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sh <= 1'b0;
			v_so <= 1'b0;
		end else begin
			v_sh <= v_sk[CORDIC_STEPS];
			v_so <= v_sh;
		end
	end

	assign out_valid   = v_so;
	assign out_cal     = cal_so;
	assign out_heading = h_so;
	assign out_sector  = sect_so;

endmodule

[hw/rtl/magnetometer_heading_compass_core.sv]
// ----------------------------------------------------------------------------
// magnetometer_heading_compass_core
// Calibrated magnetometer sample to compass heading and sector.
//
//   channel   handshake            payload
//   sample    start / busy         x_raw, y_raw, z_raw
//   result    done (one cycle)     x_cal, y_cal, z_cal, heading, sector
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle; busy is never raised. Pipeline stages in order:
// three calibration stages, fold, one stage per CORDIC iteration, heading
// wrap, sector. Reset clears valid bits and loads register defaults.
// The result side cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module magnetometer_heading_compass_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [mhc_pkg::RAW_W-1:0]     x_raw,
	input  logic signed [mhc_pkg::RAW_W-1:0]     y_raw,
	input  logic signed [mhc_pkg::RAW_W-1:0]     z_raw,
	output logic                                 done,
	output logic signed [mhc_pkg::CAL_W-1:0]     x_cal,
	output logic signed [mhc_pkg::CAL_W-1:0]     y_cal,
	output logic signed [mhc_pkg::CAL_W-1:0]     z_cal,
	output logic        [mhc_pkg::HEAD_W-1:0]    heading,
	output logic        [mhc_pkg::SECT_W-1:0]    sector,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [mhc_pkg::CFG_IW-1:0]    cfg_index,
	input  logic        [mhc_pkg::CFG_DW-1:0]    cfg_data
);
	import mhc_pkg::*;

	logic signed [OFF_W-1:0]   x_off_q, y_off_q, z_off_q;
	logic        [SCALE_W-1:0] x_scale_q, y_scale_q, z_scale_q;

	logic     v_s1, v_s2, v_s3;
	cal_vec_t cal_vec;
	cal_vec_t out_cal;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q   <= '0;
			y_off_q   <= '0;
			z_off_q   <= '0;
			x_scale_q <= SCALE_ONE;
			y_scale_q <= SCALE_ONE;
			z_scale_q <= SCALE_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_OFF:   x_off_q   <= $signed(cfg_data);
				REG_Y_OFF:   y_off_q   <= $signed(cfg_data);
				REG_Z_OFF:   z_off_q   <= $signed(cfg_data);
				REG_X_SCALE: x_scale_q <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE: y_scale_q <= cfg_data[SCALE_W-1:0];
				REG_Z_SCALE: z_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	mhc_calib u_cal_x (
		.clk       (clk),
		.raw       (x_raw),
		.off_twice (x_off_q),
		.scale     (x_scale_q),
		.cal       (cal_vec.x)
	);

	mhc_calib u_cal_y (
		.clk       (clk),
		.raw       (y_raw),
		.off_twice (y_off_q),
		.scale     (y_scale_q),
		.cal       (cal_vec.y)
	);

	mhc_calib u_cal_z (
		.clk       (clk),
		.raw       (z_raw),
		.off_twice (z_off_q),
		.scale     (z_scale_q),
		.cal       (cal_vec.z)
	);

	mhc_cordic u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s3),
		.in_cal      (cal_vec),
		.out_valid   (done),
		.out_cal     (out_cal),
		.out_heading (heading),
		.out_sector  (sector)
	);

	assign x_cal = out_cal.x;
	assign y_cal = out_cal.y;
	assign z_cal = out_cal.z;

endmodule
